FILE: rtl/printable_escape_encoder_top_assert.svh
// Assertion macros used by the printable escape encoder RTL (pee_emit).
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef PRINTABLE_ESCAPE_ENCODER_TOP_ASSERT_SVH
`define PRINTABLE_ESCAPE_ENCODER_TOP_ASSERT_SVH

// Concurrent check on the rising clock, disabled while reset is asserted.
`define PEE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check on the rising clock that also holds during reset.
`define PEE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/pee_pkg.sv
// Package for the printable escape encoder: field widths, register indexes,
// the per-item expansion plan type and the character encoding helpers.
package pee_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned ColW    = 10;
  localparam int unsigned TabW    = 4;

  localparam logic [CfgW-1:0] MaxLineWidth   = 11'd1024;
  localparam logic [CfgW-1:0] ResetLineWidth = 11'd64;
  localparam logic [TabW-1:0] ResetTabs      = 4'd0;

  localparam logic [DataW-1:0] ChNewline   = 8'h0a;
  localparam logic [DataW-1:0] ChTab       = 8'h09;
  localparam logic [DataW-1:0] ChBackslash = 8'h5c;
  localparam logic [DataW-1:0] ChFirstPrn  = 8'd32;
  localparam logic [DataW-1:0] ChLastPrn   = 8'd126;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_WIDTH  = 2'd0,
    REG_INDENT_TABS = 2'd1
  } pee_reg_e;

  // Input function codes.
  typedef enum logic {
    FUNC_ENCODE = 1'b0,
    FUNC_FINISH = 1'b1
  } pee_func_e;

  // Expansion of one item: optional newline, tabs, then one to three body chars.
  typedef struct packed {
    logic                  pre_nl;
    logic [TabW-1:0]       tabs;
    logic [1:0]            body_len;
    logic [2:0][DataW-1:0] body;
  } pee_plan_t;

  // Lower-case hex digit of a nibble.
  function automatic logic [DataW-1:0] hex_digit(input logic [3:0] nib);
    logic [DataW-1:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'd0, nib};
    end else begin
      res = 8'h61 + {4'd0, nib - 4'd10};
    end
    return res;
  endfunction

endpackage

FILE: rtl/pee_ifs.sv
// Handshake channel interfaces of the printable escape encoder.
// Depends on pee_pkg for the field widths.
interface pee_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [pee_pkg::DataW-1:0]   data_byte;
  modport source (output valid, func, data_byte, input ready);
  modport sink   (input valid, func, data_byte, output ready);
endinterface

interface pee_out_if;
  logic                        valid;
  logic                        ready;
  logic [pee_pkg::DataW-1:0]   out_char;
  logic                        last_char;
  modport source (output valid, out_char, last_char, input ready);
  modport sink   (input valid, out_char, last_char, output ready);
endinterface

interface pee_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pee_pkg::CfgIdxW-1:0] index;
  logic [pee_pkg::CfgW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/pee_plan.sv
// Accept side of the encoder: configuration registers, line position state and
// the combinational build of the expansion plan for one item. Uses pee_pkg.
module pee_plan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [pee_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pee_pkg::CfgW-1:0]    cfg_data_i,
  output logic                        cfg_ready_o,
  input  logic                        in_fire_i,
  input  logic                        func_i,
  input  logic [pee_pkg::DataW-1:0]   data_byte_i,
  output pee_pkg::pee_plan_t          plan_o
);
  import pee_pkg::*;

  logic [CfgW-1:0] line_width_q, line_width_d;
  logic [TabW-1:0] tabs_q, tabs_d;
  logic [ColW-1:0] col_q, col_d;
  logic            started_q, started_d;
  logic [CfgW-1:0] eff_width;
  logic [CfgW-1:0] col_next;
  logic            line_start;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Writes to indexes outside the register list are dropped.
  always_comb begin
    line_width_d = line_width_q;
    tabs_d       = tabs_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LINE_WIDTH: begin
          line_width_d = cfg_data_i;
        end
        REG_INDENT_TABS: begin
          tabs_d = cfg_data_i[TabW-1:0];
        end
        default: begin
          line_width_d = line_width_q;
        end
      endcase
    end
  end

  // Effective width is clamped to the range of the column count.
  always_comb begin
    priority if (line_width_q == '0) begin
      eff_width = 11'd1;
    end else if (line_width_q > MaxLineWidth) begin
      eff_width = MaxLineWidth;
    end else begin
      eff_width = line_width_q;
    end
  end

  assign col_next   = {1'b0, col_q} + 11'd1;
  assign line_start = (col_q == '0);

  // Line position advances on every accepted data beat; a finish beat resets it.
  always_comb begin
    col_d     = col_q;
    started_d = started_q;
    if (in_fire_i) begin
      if (func_i == FUNC_FINISH) begin
        col_d     = '0;
        started_d = 1'b0;
      end else begin
        col_d     = (col_next >= eff_width) ? '0 : col_next[ColW-1:0];
        started_d = 1'b1;
      end
    end
  end

  // Build the expansion of the offered item from the current state.
  always_comb begin
    plan_o          = '0;
    plan_o.body[0]  = ChNewline;
    plan_o.body_len = 2'd1;
    if (func_i == FUNC_FINISH) begin
      plan_o.pre_nl = 1'b1;
      plan_o.tabs   = tabs_q;
    end else begin
      plan_o.pre_nl = line_start && started_q;
      plan_o.tabs   = line_start ? tabs_q : '0;
      priority if (data_byte_i == ChBackslash) begin
        plan_o.body[0]  = ChBackslash;
        plan_o.body[1]  = ChBackslash;
        plan_o.body_len = 2'd2;
      end else if (data_byte_i >= ChFirstPrn && data_byte_i <= ChLastPrn) begin
        plan_o.body[0]  = data_byte_i;
        plan_o.body_len = 2'd1;
      end else begin
        plan_o.body[0]  = ChBackslash;
        plan_o.body[1]  = hex_digit(data_byte_i[7:4]);
        plan_o.body[2]  = hex_digit(data_byte_i[3:0]);
        plan_o.body_len = 2'd3;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= ResetLineWidth;
      tabs_q       <= ResetTabs;
      col_q        <= '0;
      started_q    <= 1'b0;
    end else begin
      line_width_q <= line_width_d;
      tabs_q       <= tabs_d;
      col_q        <= col_d;
      started_q    <= started_d;
    end
  end

endmodule

FILE: rtl/pee_emit.sv
// Emit side of the encoder: holds one expansion plan and walks it one character
// per cycle, while the output register can take it. Uses pee_pkg and the assertion macros.
`include "printable_escape_encoder_top_assert.svh"

module pee_emit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  pee_pkg::pee_plan_t        plan_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pee_pkg::DataW-1:0] out_char_o,
  output logic                      last_char_o
);
  import pee_pkg::*;

  logic                  plan_valid_q, plan_valid_d;
  logic                  pre_nl_q, pre_nl_d;
  logic [TabW-1:0]       tabs_q, tabs_d;
  logic [1:0]            len_q, len_d;
  logic [2:0][DataW-1:0] body_q, body_d;
  logic [1:0]            idx_q, idx_d;
  logic                  out_valid_q, out_valid_d;
  logic [DataW-1:0]      out_char_q, out_char_d;
  logic                  last_q, last_d;
  logic                  step;
  logic                  step_last;
  logic                  load;
  logic [DataW-1:0]      cur_char;

  // A character moves whenever a plan is held and the output register frees up.
  assign step      = plan_valid_q && (!out_valid_q || out_ready_i);
  assign step_last = !pre_nl_q && (tabs_q == '0) && (idx_q == len_q - 2'd1);
  assign in_ready_o = !plan_valid_q || (step && step_last);
  assign load      = in_valid_i && in_ready_o;

  // Current character of the held plan.
  always_comb begin
    priority if (pre_nl_q) begin
      cur_char = ChNewline;
    end else if (tabs_q != '0) begin
      cur_char = ChTab;
    end else begin
      cur_char = body_q[idx_q];
    end
  end

  // Plan register: loaded on an accepted beat, otherwise advanced per step.
  always_comb begin
    plan_valid_d = plan_valid_q;
    pre_nl_d     = pre_nl_q;
    tabs_d       = tabs_q;
    len_d        = len_q;
    body_d       = body_q;
    idx_d        = idx_q;
    if (load) begin
      plan_valid_d = 1'b1;
      pre_nl_d     = plan_i.pre_nl;
      tabs_d       = plan_i.tabs;
      len_d        = plan_i.body_len;
      body_d       = plan_i.body;
      idx_d        = '0;
    end else if (step) begin
      priority if (step_last) begin
        plan_valid_d = 1'b0;
      end else if (pre_nl_q) begin
        pre_nl_d = 1'b0;
      end else if (tabs_q != '0) begin
        tabs_d = tabs_q - 4'd1;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    last_d      = last_q;
    if (step) begin
      out_valid_d = 1'b1;
      out_char_d  = cur_char;
      last_d      = step_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      plan_valid_q <= plan_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_nl_q   <= pre_nl_d;
    tabs_q     <= tabs_d;
    len_q      <= len_d;
    body_q     <= body_d;
    idx_q      <= idx_d;
    out_char_q <= out_char_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = last_q;

  // The body index never runs past the body held in the plan.
  `PEE_ASSERT(a_idx_in_body, plan_valid_q |-> (idx_q < len_q), "body index past body length")
  // Finishing a plan frees the plan register unless a new beat was loaded.
  `PEE_ASSERT(a_last_frees, (step && step_last && !in_valid_i) |=> !plan_valid_q,
              "plan register not freed after its last character")
  // A new output character only appears while a plan was held.
  `PEE_ASSERT(a_out_from_plan, $rose(out_valid_q) |-> $past(plan_valid_q),
              "output became valid without a held plan")

endmodule

FILE: rtl/printable_escape_encoder_top.sv
// Top level of the printable escape encoder: binds the channel interfaces to the
// accept-side planner and the character emitter. Uses pee_pkg and pee_ifs.
//
// Bytes come in on in_i and leave as printable text on out_o, one character per
// beat, the final character of each item marked by last_char. An item yields
// 1 to 19 characters for a data byte (newline, up to indent_tabs tabs, then 1 to
// 3 encoded characters) and 2 to 17 for a finish item. The emitter's single
// output register moves one character per cycle while out_o is ready, and the
// next item is taken in the cycle its predecessor's last character leaves the
// plan, so a steady stream runs without bubbles. Register writes on cfg_i are
// taken at once and must be made while no item is in flight.
module printable_escape_encoder_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  pee_cfg_if.sink   cfg_i,
  pee_in_if.sink    in_i,
  pee_out_if.source out_o
);
  import pee_pkg::*;

  pee_plan_t plan;
  logic      in_ready;
  logic      in_fire;

  assign in_fire    = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Configuration, line position and plan build.
  pee_plan u_plan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .in_fire_i   (in_fire),
    .func_i      (in_i.func),
    .data_byte_i (in_i.data_byte),
    .plan_o      (plan)
  );

  // Character sequencer and output register.
  pee_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .plan_i      (plan),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.out_char),
    .last_char_o (out_o.last_char)
  );

endmodule

FILE: dv/tb_printable_escape_encoder_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for printable_escape_encoder_top: drives bytes and finish
// beats, predicts the escaped text stream and checks every character beat.
// Depends on pee_pkg, the channel interfaces in pee_ifs and the RTL top level.
module tb_printable_escape_encoder_top;
  import pee_pkg::*;

  // Character codes used by the hex escape and extra register indexes the block ignores.
  localparam logic [DataW-1:0]   CharZero    = 8'h30;
  localparam logic [DataW-1:0]   CharLowerA  = 8'h61;
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [DataW-1:0] out_char;
    logic             last_char;
  } enc_char_t;

  typedef struct packed {
    pee_func_e        func;
    logic [DataW-1:0] data_byte;
  } in_item_t;

  // Scoreboard: keeps its own copy of the encoder state and the queue of
  // characters that the accepted input beats must produce.
  class escape_text_scoreboard;
    logic [CfgW-1:0] line_width;
    logic [TabW-1:0] indent_tabs;
    logic [ColW-1:0] column;
    bit              started;
    enc_char_t       item_chars[$];
    enc_char_t       pending_chars[$];
    int              errors;

    function new();
      line_width  = ResetLineWidth;
      indent_tabs = ResetTabs;
      column      = '0;
      started     = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
      if (idx == REG_LINE_WIDTH) begin
        line_width = value;
      end else if (idx == REG_INDENT_TABS) begin
        indent_tabs = value[TabW-1:0];
      end
    endfunction

    function logic [DataW-1:0] nibble_char(logic [3:0] nib);
      return (nib < 4'd10) ? CharZero + nib : CharLowerA + (nib - 4'd10);
    endfunction

    function void add_char(logic [DataW-1:0] ch);
      enc_char_t c;
      c.out_char  = ch;
      c.last_char = 1'b0;
      item_chars.push_back(c);
    endfunction

    function void add_tabs();
      for (int t = 0; t < indent_tabs; t++) add_char(ChTab);
    endfunction

    // Works out the characters of one accepted input beat.
    function void note_item(pee_func_e func, logic [DataW-1:0] b);
      logic [CfgW-1:0] eff_width;
      logic [CfgW-1:0] next_col;
      item_chars.delete();
      eff_width = line_width;
      if (eff_width == '0) eff_width = 11'd1;
      if (eff_width > MaxLineWidth) eff_width = MaxLineWidth;

      if (func == FUNC_FINISH) begin
        add_char(ChNewline);
        add_tabs();
        add_char(ChNewline);
        column  = '0;
        started = 1'b0;
      end else begin
        // A new line starts with a newline (unless nothing came yet) and the indent.
        if (column == '0) begin
          if (started) add_char(ChNewline);
          add_tabs();
        end
        if (b >= ChFirstPrn && b <= ChLastPrn && b != ChBackslash) begin
          add_char(b);
        end else if (b == ChBackslash) begin
          add_char(ChBackslash);
          add_char(ChBackslash);
        end else begin
          add_char(ChBackslash);
          add_char(nibble_char(b[7:4]));
          add_char(nibble_char(b[3:0]));
        end
        started  = 1'b1;
        next_col = {1'b0, column} + 1'b1;
        column   = (next_col >= eff_width) ? '0 : next_col[ColW-1:0];
      end

      item_chars[item_chars.size()-1].last_char = 1'b1;
      foreach (item_chars[k]) pending_chars.push_back(item_chars[k]);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t ns] mismatch: %s", $time, msg);
    endtask

    // Compares one output beat with the oldest expected character.
    task check_char(logic [DataW-1:0] ch, logic last);
      enc_char_t exp_c;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last %0b", ch, last));
        return;
      end
      exp_c = pending_chars.pop_front();
      if (ch !== exp_c.out_char)
        report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h", ch, exp_c.out_char));
      if (last !== exp_c.last_char)
        report_mismatch($sformatf("last_char %0b, expected %0b on char 0x%02h",
                                  last, exp_c.last_char, exp_c.out_char));
    endtask

    function int chars_pending();
      return pending_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_rx;

  escape_text_scoreboard sb;
  in_item_t              item_queue[$];

  logic [CfgW-1:0] phase_width [8] = '{11'd1, 11'd1024, 11'd5, 11'd2047,
                                       11'd0, 11'd17, 11'd64, 11'd2};
  logic [CfgW-1:0] phase_tabs  [8] = '{11'd0, 11'd15, 11'd3, 11'h7f7,
                                       11'd1, 11'd15, 11'd0, 11'd2};

  pee_cfg_if cfg_if ();
  pee_in_if  in_if ();
  pee_out_if out_if ();

  printable_escape_encoder_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Hard limit on the run time.
  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

  // Output side: checks each accepted character beat, then picks the next ready.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready)
        sb.check_char(out_if.out_char, out_if.last_char);
      if (hold_rx) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic set_idle_mode(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 69 : (mode == IDLE_BOTH) ? 18 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 69 : (mode == IDLE_BOTH) ? 18 : 0;
  endtask

  // Writes the two registers back to back, optionally followed by the unused indexes.
  task automatic apply_config(input logic [CfgW-1:0] width, input logic [CfgW-1:0] tabs,
                              input bit poke_unused);
    logic [CfgIdxW-1:0] idx_list [4];
    logic [CfgW-1:0]    val_list [4];
    int                 n;
    idx_list[0] = REG_LINE_WIDTH;
    val_list[0] = width;
    idx_list[1] = REG_INDENT_TABS;
    val_list[1] = tabs;
    n = 2;
    if (poke_unused) begin
      idx_list[2] = RegUnusedLo;
      val_list[2] = CfgW'($urandom);
      idx_list[3] = RegUnusedHi;
      val_list[3] = CfgW'($urandom);
      n = 4;
    end
    for (int k = 0; k < n; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx_list[k];
      cfg_if.data  <= val_list[k];
      do @(posedge clk); while (!cfg_if.ready);
      sb.write_reg(idx_list[k], val_list[k]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Offers one input beat after a random gap and waits until it is taken.
  task automatic send_item(input pee_func_e func, input logic [DataW-1:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= func;
    in_if.data_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(func, b);
  endtask

  task automatic send_queued();
    in_item_t it;
    while (item_queue.size() != 0) begin
      it = item_queue.pop_front();
      send_item(it.func, it.data_byte);
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic queue_byte(input logic [DataW-1:0] b);
    item_queue.push_back(in_item_t'{FUNC_ENCODE, b});
  endtask

  task automatic queue_finish();
    item_queue.push_back(in_item_t'{FUNC_FINISH, DataW'($urandom)});
  endtask

  // Byte mix weighted toward the escape classes: printable, backslash, control, high.
  function automatic logic [DataW-1:0] pick_byte();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return DataW'($urandom_range(126, 32));
    if (sel < 50) return ChBackslash;
    if (sel < 70) return DataW'($urandom_range(31, 0));
    return DataW'($urandom_range(255, 127));
  endfunction

  task automatic queue_random_items(input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 6) begin
        queue_finish();
      end else begin
        queue_byte(pick_byte());
      end
    end
  endtask

  // Waits until every expected character has left the block.
  task automatic wait_idle();
    while (sb.chars_pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Main sequence: reset, directed cases, random phases, back-pressure, drain.
  initial begin
    sb = new();
    hold_rx         = 1'b0;
    rst_n           = 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;
    in_if.valid     <= 1'b0;
    in_if.func      <= FUNC_ENCODE;
    in_if.data_byte <= '0;
    set_idle_mode(IDLE_NONE);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: finish with no data, then the byte class boundaries.
    queue_finish();
    queue_byte(8'h00);
    queue_byte(8'h1f);
    queue_byte(8'h20);
    queue_byte(8'h7e);
    queue_byte(8'h7f);
    queue_byte(8'h5c);
    queue_byte(8'hff);
    queue_byte(8'h41);
    queue_finish();
    send_queued();
    wait_idle();

    // Short lines with the deepest indent; the upper tab bits must be dropped.
    apply_config(11'd3, 11'h7ff, 1'b1);
    queue_byte(8'h00);
    queue_byte(8'h5c);
    queue_byte(8'h41);
    queue_byte(8'h7e);
    queue_byte(8'h0a);
    queue_finish();
    send_queued();
    wait_idle();

    // A zero width behaves as one byte per line.
    apply_config(11'd0, 11'd1, 1'b0);
    queue_byte(8'h61);
    queue_byte(8'h62);
    send_queued();
    wait_idle();

    // Width lowered below the current column wraps on the next byte.
    apply_config(11'd10, 11'd2, 1'b0);
    queue_byte(8'h30);
    queue_byte(8'h31);
    queue_byte(8'h32);
    queue_byte(8'h33);
    send_queued();
    wait_idle();
    apply_config(11'd3, 11'd2, 1'b0);
    queue_byte(8'h35);
    queue_byte(8'h36);
    send_queued();
    wait_idle();

    // A width above the maximum saturates.
    apply_config(11'd2047, 11'd0, 1'b0);
    queue_byte(8'h37);
    queue_finish();
    send_queued();
    wait_idle();

    // Random phases, cycling through the idle patterns and register settings.
    for (int p = 0; p < 8; p++) begin
      set_idle_mode(idle_mode_e'(p % 4));
      apply_config(phase_width[p], phase_tabs[p], p == 3);
      queue_random_items(42);
      send_queued();
      wait_idle();
    end

    // Output held off for a long stretch while the input keeps offering beats.
    set_idle_mode(IDLE_NONE);
    apply_config(11'd4, 11'd15, 1'b0);
    queue_random_items(40);
    fork
      send_queued();
      begin
        hold_rx <= 1'b1;
        repeat (300) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join
    wait_idle();
    repeat (30) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pee_pkg.sv
rtl/pee_ifs.sv
rtl/pee_plan.sv
rtl/pee_emit.sv
rtl/printable_escape_encoder_top.sv
dv/tb_printable_escape_encoder_top.sv
